### hdl/mck_pkg.sv
package mck_pkg;

   localparam int SymbolWidth   = 8;
   localparam int WpmWidth      = 6;
   localparam int DotWidth      = 11;
   localparam int UnitsWidth    = 3;
   localparam int DurationWidth = 13;
   localparam int PatternWidth  = 6;
   localparam int CountWidth    = 3;
   localparam int TableDepth    = 39;
   localparam int IndexWidth    = 6;

   localparam logic [SymbolWidth-1:0] CharSpace  = 8'h20;
   localparam logic [SymbolWidth-1:0] CharPeriod = 8'h2E;
   localparam logic [SymbolWidth-1:0] CharComma  = 8'h2C;
   localparam logic [SymbolWidth-1:0] CharZero   = 8'h30;
   localparam logic [SymbolWidth-1:0] CharNine   = 8'h39;
   localparam logic [SymbolWidth-1:0] CharUpperA = 8'h41;
   localparam logic [SymbolWidth-1:0] CharUpperZ = 8'h5A;
   localparam logic [SymbolWidth-1:0] LetterBase = 8'd52;
   localparam logic [SymbolWidth-1:0] DigitBase  = 8'd45;
   localparam logic [IndexWidth-1:0]  IndexComma  = 6'd2;
   localparam logic [IndexWidth-1:0]  IndexPeriod = 6'd1;

   localparam logic [UnitsWidth-1:0] UnitsDot   = 3'd1;
   localparam logic [UnitsWidth-1:0] UnitsGap   = 3'd2;
   localparam logic [UnitsWidth-1:0] UnitsDash  = 3'd3;
   localparam logic [UnitsWidth-1:0] UnitsSpace = 3'd4;
   localparam logic [UnitsWidth-1:0] UnitsNone  = 3'd0;

   // Dot length in milliseconds, 1200 / wpm, with the speed clamped to 1..50.
   localparam logic [DotWidth-1:0] DotTable [64] = '{
      11'd1200, 11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200, 11'd171,
      11'd150,  11'd133,  11'd120, 11'd109, 11'd100, 11'd92,  11'd85,  11'd80,
      11'd75,   11'd70,   11'd66,  11'd63,  11'd60,  11'd57,  11'd54,  11'd52,
      11'd50,   11'd48,   11'd46,  11'd44,  11'd42,  11'd41,  11'd40,  11'd38,
      11'd37,   11'd36,   11'd35,  11'd34,  11'd33,  11'd32,  11'd31,  11'd30,
      11'd30,   11'd29,   11'd28,  11'd27,  11'd27,  11'd26,  11'd26,  11'd25,
      11'd25,   11'd24,   11'd24,  11'd24,  11'd24,  11'd24,  11'd24,  11'd24,
      11'd24,   11'd24,   11'd24,  11'd24,  11'd24,  11'd24,  11'd24,  11'd24
   };

   localparam logic [DotWidth-1:0] DotReset = DotTable[12];

   localparam logic [CountWidth-1:0] ElemCount [TableDepth] = '{
      3'd4, 3'd6, 3'd6,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   localparam logic [PatternWidth-1:0] ElemBits [TableDepth] = '{
      6'h00, 6'h15, 6'h33,
      6'h1F, 6'h0F, 6'h07, 6'h03, 6'h01, 6'h00, 6'h10, 6'h18, 6'h1C, 6'h1E,
      6'h01, 6'h08, 6'h0A, 6'h04, 6'h00, 6'h02, 6'h06, 6'h00, 6'h00, 6'h07, 6'h05,
      6'h04, 6'h03,
      6'h02, 6'h07, 6'h06, 6'h0D, 6'h02, 6'h00, 6'h01, 6'h01, 6'h01, 6'h03, 6'h09,
      6'h0B, 6'h0C
   };

   typedef enum logic [1:0] {
      SK_SPACE,
      SK_UNSUP,
      SK_CODE
   } seg_kind_type;

   typedef enum logic {
      KS_IDLE,
      KS_EMIT
   } keyer_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } keyer_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic seg_last;
   } keyer_status_type;

endpackage

### hdl/morse_character_keyer_unit.sv
// The character is decoded and loaded when accepted; the controller then steps out its segments.
// Throughput: one segment word per cycle while the output is not stalled; a character of n
// elements gives 2n element words and one gap word; space and unsupported give one word.
// Output backpressure stalls the segment sequencer one word at a time.
// Reset is synchronous and active high; it empties the output register and sets 12 wpm.
module morse_character_keyer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] key_on, [3:1] dot_units, [16:4] duration_ms, zeros
   output logic        rsp_tuser,   // [0] unsupported
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // words_per_minute
);

   mck_pkg::keyer_cmd_type    cmd;
   mck_pkg::keyer_status_type status;

   logic                                rsp_key_on;
   logic [mck_pkg::UnitsWidth-1:0]      rsp_dot_units;
   logic [mck_pkg::DurationWidth-1:0]   rsp_duration_ms;

   mck_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mck_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .symbol           (req_tdata),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_key_on       (rsp_key_on),
      .rsp_dot_units    (rsp_dot_units),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_unsupported  (rsp_tuser),
      .rsp_last_segment (rsp_tlast)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {7'd0, rsp_duration_ms, rsp_dot_units, rsp_key_on};

endmodule

### hdl/mck_ctrl.sv
module mck_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  mck_pkg::keyer_status_type status,
   output mck_pkg::keyer_cmd_type    cmd
);

   mck_pkg::keyer_state_type state_ff;
   mck_pkg::keyer_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mck_pkg::KS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         mck_pkg::KS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = mck_pkg::KS_EMIT;
            end
         end
         mck_pkg::KS_EMIT: begin
            if (status.slot_free) begin
               cmd.step = 1'b1;
               if (status.seg_last) begin
                  state_in = mck_pkg::KS_IDLE;
               end
            end
         end
         default: begin
            state_in = mck_pkg::KS_IDLE;
         end
      endcase
   end

endmodule

### hdl/mck_datapath.sv
module mck_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mck_pkg::keyer_cmd_type                 cmd,
   output mck_pkg::keyer_status_type              status,
   input  logic [mck_pkg::SymbolWidth-1:0]        symbol,
   input  logic                                   csr_valid,
   input  logic [mck_pkg::WpmWidth-1:0]           csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_key_on,
   output logic [mck_pkg::UnitsWidth-1:0]         rsp_dot_units,
   output logic [mck_pkg::DurationWidth-1:0]      rsp_duration_ms,
   output logic                                   rsp_unsupported,
   output logic                                   rsp_last_segment
);

   logic [mck_pkg::DotWidth-1:0]      dot_ff;
   logic [mck_pkg::DotWidth-1:0]      dot_in;
   mck_pkg::seg_kind_type             kind_ff;
   mck_pkg::seg_kind_type             kind_in;
   logic [mck_pkg::CountWidth-1:0]    remain_ff;
   logic [mck_pkg::CountWidth-1:0]    remain_in;
   logic [mck_pkg::PatternWidth-1:0]  pattern_ff;
   logic [mck_pkg::PatternWidth-1:0]  pattern_in;
   logic                              phase_ff;
   logic                              phase_in;
   logic                              valid_ff;
   logic                              valid_in;
   logic                              key_on_ff;
   logic [mck_pkg::UnitsWidth-1:0]    units_ff;
   logic [mck_pkg::DurationWidth-1:0] duration_ff;
   logic                              unsup_ff;
   logic                              last_ff;

   logic [mck_pkg::IndexWidth-1:0]    index;
   mck_pkg::seg_kind_type             load_kind;
   logic [mck_pkg::CountWidth-1:0]    load_count;
   logic [mck_pkg::PatternWidth-1:0]  load_bits;
   logic                              seg_key_on;
   logic [mck_pkg::UnitsWidth-1:0]    seg_units;
   logic                              seg_unsup;
   logic                              seg_last;
   logic [mck_pkg::DurationWidth:0]   seg_product;

   // Character decode into a table index.
   always_comb begin
      index     = '0;
      load_kind = mck_pkg::SK_CODE;
      if (symbol == mck_pkg::CharSpace) begin
         load_kind = mck_pkg::SK_SPACE;
      end else if (symbol >= mck_pkg::CharUpperA && symbol <= mck_pkg::CharUpperZ) begin
         index = mck_pkg::IndexWidth'(symbol - mck_pkg::LetterBase);
      end else if (symbol >= mck_pkg::CharZero && symbol <= mck_pkg::CharNine) begin
         index = mck_pkg::IndexWidth'(symbol - mck_pkg::DigitBase);
      end else if (symbol == mck_pkg::CharComma) begin
         index = mck_pkg::IndexComma;
      end else if (symbol == mck_pkg::CharPeriod) begin
         index = mck_pkg::IndexPeriod;
      end else begin
         load_kind = mck_pkg::SK_UNSUP;
      end
      load_count = mck_pkg::ElemCount[index];
      load_bits  = mck_pkg::ElemBits[index];
   end

   // The segment that the next step emits.
   always_comb begin
      seg_key_on = 1'b0;
      seg_units  = mck_pkg::UnitsNone;
      seg_unsup  = 1'b0;
      seg_last   = 1'b0;
      case (kind_ff)
         mck_pkg::SK_SPACE: begin
            seg_units = mck_pkg::UnitsSpace;
            seg_last  = 1'b1;
         end
         mck_pkg::SK_UNSUP: begin
            seg_unsup = 1'b1;
            seg_last  = 1'b1;
         end
         mck_pkg::SK_CODE: begin
            if (remain_ff == '0) begin
               seg_units = mck_pkg::UnitsGap;
               seg_last  = 1'b1;
            end else if (!phase_ff) begin
               seg_key_on = 1'b1;
               seg_units  = pattern_ff[mck_pkg::PatternWidth-1] ? mck_pkg::UnitsDash
                                                                : mck_pkg::UnitsDot;
            end else begin
               seg_units = mck_pkg::UnitsDot;
            end
         end
         default: begin
            seg_last = 1'b1;
         end
      endcase
      seg_product = (mck_pkg::DurationWidth+1)'(seg_units)
                  * (mck_pkg::DurationWidth+1)'(dot_ff);
   end

   always_comb begin
      kind_in    = kind_ff;
      remain_in  = remain_ff;
      pattern_in = pattern_ff;
      phase_in   = phase_ff;
      if (cmd.load) begin
         kind_in    = load_kind;
         remain_in  = load_count;
         pattern_in = load_bits << (mck_pkg::CountWidth'(mck_pkg::PatternWidth) - load_count);
         phase_in   = 1'b0;
      end else if (cmd.step && kind_ff == mck_pkg::SK_CODE && remain_ff != '0) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in   = 1'b0;
            remain_in  = remain_ff - 1'b1;
            pattern_in = pattern_ff << 1;
         end
      end
   end

   assign dot_in   = csr_valid ? mck_pkg::DotTable[csr_data] : dot_ff;
   assign valid_in = cmd.step ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= mck_pkg::DotReset;
         valid_ff <= 1'b0;
         kind_ff  <= mck_pkg::SK_UNSUP;
      end else begin
         dot_ff   <= dot_in;
         valid_ff <= valid_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff  <= remain_in;
      pattern_ff <= pattern_in;
      phase_ff   <= phase_in;
      if (cmd.step) begin
         key_on_ff   <= seg_key_on;
         units_ff    <= seg_units;
         duration_ff <= seg_product[mck_pkg::DurationWidth-1:0];
         unsup_ff    <= seg_unsup;
         last_ff     <= seg_last;
      end
   end

   assign status.slot_free = !valid_ff || rsp_ready;
   assign status.seg_last  = seg_last;

   assign rsp_valid        = valid_ff;
   assign rsp_key_on       = key_on_ff;
   assign rsp_dot_units    = units_ff;
   assign rsp_duration_ms  = duration_ff;
   assign rsp_unsupported  = unsup_ff;
   assign rsp_last_segment = last_ff;

   a_unsup_single : assert property (@(posedge clock) disable iff (reset)
      valid_ff && unsup_ff |-> last_ff && units_ff == mck_pkg::UnitsNone && !key_on_ff)
      else $error("unsupported word is not a single empty segment");

   a_key_on_shape : assert property (@(posedge clock) disable iff (reset)
      valid_ff && key_on_ff |->
         !last_ff && (units_ff == mck_pkg::UnitsDot || units_ff == mck_pkg::UnitsDash))
      else $error("key-on segment has wrong length or ends the character");

   a_on_then_off : assert property (@(posedge clock) disable iff (reset)
      cmd.step && seg_key_on |=> kind_ff == mck_pkg::SK_CODE && phase_ff)
      else $error("key-on element not followed by its key-off space");

   a_no_load_while_busy : assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.step)
      else $error("load and step issued together");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HoldCycles = 400;

   typedef struct packed {
      logic                              key_on;
      logic [mck_pkg::UnitsWidth-1:0]    dot_units;
      logic [mck_pkg::DurationWidth-1:0] duration_ms;
      logic                              unsupported;
      logic                              last_segment;
   } segment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   logic [7:0]  symbol_queue[$];
   segment_type segment_queue[$];
   logic [5:0]  keyer_speed;
   int          mismatches = 0;
   int          sender_idle_pct = 0;
   int          sink_stall_pct = 0;
   int          hold_left = 0;
   logic        hold_request = 1'b0;
   logic        req_fire = 1'b0;
   logic        csr_taken = 1'b0;

   morse_character_keyer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic string morse_pattern(input logic [7:0] ch);
      case (ch)
         "A": return ".-";     "B": return "-...";   "C": return "-.-.";
         "D": return "-..";    "E": return ".";      "F": return "..-.";
         "G": return "--.";    "H": return "....";   "I": return "..";
         "J": return ".---";   "K": return "-.-";    "L": return ".-..";
         "M": return "--";     "N": return "-.";     "O": return "---";
         "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
         "S": return "...";    "T": return "-";      "U": return "..-";
         "V": return "...-";   "W": return ".--";    "X": return "-..-";
         "Y": return "-.--";   "Z": return "--..";
         "0": return "-----";  "1": return ".----";  "2": return "..---";
         "3": return "...--";  "4": return "....-";  "5": return ".....";
         "6": return "-....";  "7": return "--...";  "8": return "---..";
         "9": return "----.";
         mck_pkg::CharPeriod: return ".-.-.-";
         mck_pkg::CharComma:  return "--..--";
         default: return "";
      endcase
   endfunction

   function automatic segment_type make_segment(input logic on,
                                                input logic [mck_pkg::UnitsWidth-1:0] units,
                                                input int unsigned dot, input logic unsup,
                                                input logic last);
      segment_type seg;
      seg.key_on       = on;
      seg.dot_units    = units;
      seg.duration_ms  = mck_pkg::DurationWidth'(units * dot);
      seg.unsupported  = unsup;
      seg.last_segment = last;
      return seg;
   endfunction

   task automatic predict_segments(input logic [7:0] ch);
      string       pattern;
      int unsigned speed;
      int unsigned dot;
      speed = 32'(keyer_speed);
      if (speed < 1) begin
         speed = 1;
      end else if (speed > 50) begin
         speed = 50;
      end
      dot = 1200 / speed;
      pattern = morse_pattern(ch);
      if (ch == mck_pkg::CharSpace) begin
         segment_queue.push_back(make_segment(1'b0, mck_pkg::UnitsSpace, dot, 1'b0, 1'b1));
      end else if (pattern.len() == 0) begin
         segment_queue.push_back(make_segment(1'b0, mck_pkg::UnitsNone, dot, 1'b1, 1'b1));
      end else begin
         for (int i = 0; i < pattern.len(); i++) begin
            segment_queue.push_back(make_segment(1'b1,
                                                 (pattern[i] == "-") ? mck_pkg::UnitsDash
                                                                     : mck_pkg::UnitsDot,
                                                 dot, 1'b0, 1'b0));
            segment_queue.push_back(make_segment(1'b0, mck_pkg::UnitsDot, dot, 1'b0, 1'b0));
         end
         segment_queue.push_back(make_segment(1'b0, mck_pkg::UnitsGap, dot, 1'b0, 1'b1));
      end
   endtask

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Character driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (symbol_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= symbol_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Segment receiver.
   always @(negedge clock) begin
      rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_left <= HoldCycles;
      end
   end

   always @(posedge clock) begin
      segment_type want;
      req_fire  = !reset && req_tvalid && req_tready;
      csr_taken = !reset && csr_valid && csr_ready;
      if (reset) begin
         keyer_speed = 6'd12;
      end else begin
         if (csr_taken) begin
            keyer_speed = csr_data;
         end
         if (req_fire) begin
            predict_segments(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (segment_queue.size() == 0) begin
               $error("segment word with none expected: tdata %h, tuser %b, tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = segment_queue.pop_front();
               compare_field("key_on", 32'(want.key_on), 32'(rsp_tdata[0]));
               compare_field("dot_units", 32'(want.dot_units), 32'(rsp_tdata[3:1]));
               compare_field("duration_ms", 32'(want.duration_ms), 32'(rsp_tdata[16:4]));
               compare_field("unsupported", 32'(want.unsupported), 32'(rsp_tuser));
               compare_field("last_segment", 32'(want.last_segment), 32'(rsp_tlast));
            end
         end
      end
   end

   task automatic wait_until_idle();
      do @(negedge clock);
      while (symbol_queue.size() != 0 || (req_tvalid && !req_fire) || segment_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_speed(input logic [5:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(negedge clock);
      while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_symbols(input int count);
      string alphabet;
      alphabet = "ETAOINSHRDLUCMFWYPVBGKQJXZ0123456789., ";
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 80) begin
            symbol_queue.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
         end else begin
            symbol_queue.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{mck_pkg::CharSpace, mck_pkg::CharPeriod, mck_pkg::CharComma,
                   mck_pkg::CharZero, mck_pkg::CharNine, mck_pkg::CharUpperA,
                   mck_pkg::CharUpperZ,
                   "E", "T", "Q", "J", "5", 8'h00, 8'hFF, "a", "z", "/", "@", "[", ":",
                   8'h80, 8'h7F, 8'h55, 8'hAA};
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) symbol_queue.push_back(directed[i]);
      wait_until_idle();

      write_speed(6'd0);
      queue_random_symbols(60);
      wait_until_idle();

      write_speed(6'd50);
      sender_idle_pct = 76;
      queue_random_symbols(60);
      wait_until_idle();

      write_speed(6'd63);
      sender_idle_pct = 0;
      sink_stall_pct  = 76;
      queue_random_symbols(60);
      wait_until_idle();

      write_speed(6'd1);
      sender_idle_pct = 26;
      sink_stall_pct  = 26;
      queue_random_symbols(60);
      wait_until_idle();

      write_speed(6'd51);
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      queue_random_symbols(40);
      @(posedge clock);
      hold_request = 1'b1;
      wait (hold_left != 0);
      @(posedge clock);
      hold_request = 1'b0;
      wait_until_idle();

      write_speed(6'($urandom_range(1, 50)));
      sender_idle_pct = 26;
      sink_stall_pct  = 26;
      queue_random_symbols(60);
      wait_until_idle();

      repeat (20) @(negedge clock);
      if (mismatches == 0 && segment_queue.size() == 0) begin
         $display("morse_character_keyer_unit test passed");
      end else begin
         $display("morse_character_keyer_unit test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("morse_character_keyer_unit test failed");
      $finish;
   end

endmodule
